// ===== rtl/rbsi_pkg.sv =====
// Shared types for the 2D ray versus box slab test.
package rbsi_pkg;

    typedef struct packed {
        logic dir_zero;
        logic outside;
    } t_slab_flags;

    localparam int unsigned FLAG_W = $bits(t_slab_flags);

endpackage

// ===== rtl/rbsi_if.sv =====
// Request and response channel interfaces of the slab test.
interface rbsi_in_if #(
    parameter int CW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] ray_x;
    logic signed [CW-1:0] ray_y;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] box_center_x;
    logic signed [CW-1:0] box_center_y;
    logic        [CW-2:0] half_width;
    logic        [CW-2:0] half_height;

    modport source (
        output valid, ray_x, ray_y, dir_x, dir_y, box_center_x, box_center_y,
               half_width, half_height,
        input  ready
    );
    modport sink (
        input  valid, ray_x, ray_y, dir_x, dir_y, box_center_x, box_center_y,
               half_width, half_height,
        output ready
    );
endinterface

interface rbsi_out_if #(
    parameter int CW = 32
);
    logic                 valid;
    logic                 ready;
    logic                 is_hit;
    logic signed [CW-1:0] hit_time;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;

    modport source (
        output valid, is_hit, hit_time, hit_x, hit_y,
        input  ready
    );
    modport sink (
        input  valid, is_hit, hit_time, hit_x, hit_y,
        output ready
    );
endinterface

// ===== rtl/ray_box_slab_intersect_2d.sv =====
// Top level of the 2D ray segment versus axis-aligned box slab test.
// i_req carries one request: ray origin, segment extent, box center (signed) and
// half sizes (unsigned), all fixed point with FRAC_BITS fraction bits. o_rsp returns
// one response per request, in order: is_hit, entry time and entry point,
// with time and point zero on a miss.
// A request is taken on any cycle with valid and ready high; one request per
// cycle is sustained while the skid register is empty. The pipeline holds
// two front stages, a divider setup stage, one stage per quotient bit of the
// two two-lane pipelined slab dividers, five merge/multiply/point stages and the
// output register. The dividers set the depth.
// A stalled receiver is absorbed by a one-entry skid register behind the
// output register; only when the skid holds a response does the pipeline
// freeze and i_req.ready drop, so nothing is lost or repeated.
// Synchronous reset clears all valid bits; the block then takes requests
// on the next cycle.
module ray_box_slab_intersect_2d #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rbsi_in_if.sink        i_req,
    rbsi_out_if.source     o_rsp
);
    localparam int CW = COORD_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int NW = CW + 2 + FB;
    localparam int FW = rbsi_pkg::FLAG_W;
    localparam int SW = FW + 2 * CW;

    logic                  en;
    logic signed [CW-1:0]  org_in[2], dir_in[2], ctr_in[2];
    logic        [CW-2:0]  half_in[2];

    logic                  f_v[2];
    logic        [NW-1:0]  f_mag_lo[2], f_mag_hi[2];
    logic                  f_neg_lo[2], f_neg_hi[2];
    logic        [CW-1:0]  f_dmag[2];
    rbsi_pkg::t_slab_flags f_flags[2];
    logic signed [CW-1:0]  f_org[2], f_dir[2];

    logic                  d_v[2];
    logic        [CW-1:0]  d_q_lo[2], d_q_hi[2];
    logic                  d_neg_lo[2], d_neg_hi[2], d_ovf_lo[2], d_ovf_hi[2];
    logic        [SW-1:0]  d_side[2];
    rbsi_pkg::t_slab_flags d_flags[2];
    logic signed [CW-1:0]  d_org[2], d_dir[2];

    logic                  h_v, h_hit;
    logic signed [CW-1:0]  h_time, h_x, h_y;

    logic                  r_out_v, r_out_hit, r_sk_v, r_sk_hit;
    logic signed [CW-1:0]  r_out_time, r_out_x, r_out_y;
    logic signed [CW-1:0]  r_sk_time, r_sk_x, r_sk_y;
    logic                  fire;

    assign en          = !r_sk_v;
    assign i_req.ready = en;

    assign org_in[0]  = i_req.ray_x;
    assign org_in[1]  = i_req.ray_y;
    assign dir_in[0]  = i_req.dir_x;
    assign dir_in[1]  = i_req.dir_y;
    assign ctr_in[0]  = i_req.box_center_x;
    assign ctr_in[1]  = i_req.box_center_y;
    assign half_in[0] = i_req.half_width;
    assign half_in[1] = i_req.half_height;

    for (genvar a = 0; a < 2; a++) begin : g_axis
        rbsi_slab_front #(.CW(CW), .FB(FB)) u_front (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (i_req.valid),
            .i_org    (org_in[a]),
            .i_dir    (dir_in[a]),
            .i_ctr    (ctr_in[a]),
            .i_half   (half_in[a]),
            .o_valid  (f_v[a]),
            .o_mag_lo (f_mag_lo[a]),
            .o_mag_hi (f_mag_hi[a]),
            .o_neg_lo (f_neg_lo[a]),
            .o_neg_hi (f_neg_hi[a]),
            .o_dmag   (f_dmag[a]),
            .o_flags  (f_flags[a]),
            .o_org    (f_org[a]),
            .o_dir    (f_dir[a])
        );

        rbsi_slab_div #(.CW(CW), .FB(FB), .SW(SW)) u_div (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (f_v[a]),
            .i_mag_lo (f_mag_lo[a]),
            .i_mag_hi (f_mag_hi[a]),
            .i_neg_lo (f_neg_lo[a]),
            .i_neg_hi (f_neg_hi[a]),
            .i_dmag   (f_dmag[a]),
            .i_side   ({f_flags[a], f_org[a], f_dir[a]}),
            .o_valid  (d_v[a]),
            .o_q_lo   (d_q_lo[a]),
            .o_q_hi   (d_q_hi[a]),
            .o_neg_lo (d_neg_lo[a]),
            .o_neg_hi (d_neg_hi[a]),
            .o_ovf_lo (d_ovf_lo[a]),
            .o_ovf_hi (d_ovf_hi[a]),
            .o_side   (d_side[a])
        );

        assign d_flags[a] = rbsi_pkg::t_slab_flags'(d_side[a][SW-1 -: FW]);
        assign d_org[a]   = $signed(d_side[a][2*CW-1:CW]);
        assign d_dir[a]   = $signed(d_side[a][CW-1:0]);
    end

    rbsi_hit #(.CW(CW), .FB(FB)) u_hit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (d_v[0] && d_v[1]),
        .i_q_lo   (d_q_lo),
        .i_q_hi   (d_q_hi),
        .i_neg_lo (d_neg_lo),
        .i_neg_hi (d_neg_hi),
        .i_ovf_lo (d_ovf_lo),
        .i_ovf_hi (d_ovf_hi),
        .i_flags  (d_flags),
        .i_org    (d_org),
        .i_dir    (d_dir),
        .o_valid  (h_v),
        .o_is_hit (h_hit),
        .o_time   (h_time),
        .o_x      (h_x),
        .o_y      (h_y)
    );

    assign fire = r_out_v && o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else begin
            priority if (r_sk_v) begin
                if (fire) begin
                    r_sk_v <= 1'b0;
                end
            end else if (h_v) begin
                if (!r_out_v || fire) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_sk_v <= 1'b1;
                end
            end else if (fire) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_sk_v) begin
            if (fire) begin
                r_out_hit  <= r_sk_hit;
                r_out_time <= r_sk_time;
                r_out_x    <= r_sk_x;
                r_out_y    <= r_sk_y;
            end
        end else if (h_v) begin
            if (!r_out_v || fire) begin
                r_out_hit  <= h_hit;
                r_out_time <= h_time;
                r_out_x    <= h_x;
                r_out_y    <= h_y;
            end else begin
                r_sk_hit  <= h_hit;
                r_sk_time <= h_time;
                r_sk_x    <= h_x;
                r_sk_y    <= h_y;
            end
        end
    end

    assign o_rsp.valid    = r_out_v;
    assign o_rsp.is_hit   = r_out_hit;
    assign o_rsp.hit_time = r_out_time;
    assign o_rsp.hit_x    = r_out_x;
    assign o_rsp.hit_y    = r_out_y;
endmodule

// ===== rtl/rbsi_slab_front.sv =====
// Per-axis front end: slab bounds, numerator and divisor magnitudes, flags.
module rbsi_slab_front #(
    parameter  int CW = 32,
    parameter  int FB = 16,
    localparam int NW = CW + 2 + FB
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [CW-1:0]   i_org,
    input  logic signed [CW-1:0]   i_dir,
    input  logic signed [CW-1:0]   i_ctr,
    input  logic        [CW-2:0]   i_half,
    output logic                   o_valid,
    output logic        [NW-1:0]   o_mag_lo,
    output logic        [NW-1:0]   o_mag_hi,
    output logic                   o_neg_lo,
    output logic                   o_neg_hi,
    output logic        [CW-1:0]   o_dmag,
    output rbsi_pkg::t_slab_flags  o_flags,
    output logic signed [CW-1:0]   o_org,
    output logic signed [CW-1:0]   o_dir
);
    logic signed [CW+1:0] ctr_x, half_x, org_x, lo, hi, n_nlo, n_nhi;
    logic signed [CW+1:0] r_nlo, r_nhi;
    logic signed [CW-1:0] r_org, r_dir;
    logic                 r_v1;
    logic        [CW+1:0] abs_lo, abs_hi;
    logic                 dz;
    logic        [CW-1:0] dmag;

    assign ctr_x  = (CW+2)'(i_ctr);
    assign org_x  = (CW+2)'(i_org);
    assign half_x = {3'b000, i_half};
    assign lo     = ctr_x - half_x;
    assign hi     = ctr_x + half_x;
    assign n_nlo  = lo - org_x;
    assign n_nhi  = hi - org_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nlo <= n_nlo;
            r_nhi <= n_nhi;
            r_org <= i_org;
            r_dir <= i_dir;
        end
    end

    assign abs_lo = r_nlo[CW+1] ? $unsigned(-r_nlo) : $unsigned(r_nlo);
    assign abs_hi = r_nhi[CW+1] ? $unsigned(-r_nhi) : $unsigned(r_nhi);
    assign dz     = (r_dir == '0);
    assign dmag   = dz ? CW'(1) : (r_dir[CW-1] ? $unsigned(-r_dir) : $unsigned(r_dir));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mag_lo         <= {abs_lo, {FB{1'b0}}};
            o_mag_hi         <= {abs_hi, {FB{1'b0}}};
            o_neg_lo         <= r_nlo[CW+1] ^ r_dir[CW-1];
            o_neg_hi         <= r_nhi[CW+1] ^ r_dir[CW-1];
            o_dmag           <= dmag;
            o_flags.dir_zero <= dz;
            // origin on or beyond a bound
            o_flags.outside  <= !r_nlo[CW+1] || r_nhi[CW+1] || (r_nhi == '0);
            o_org            <= r_org;
            o_dir            <= r_dir;
        end
    end
endmodule

// ===== rtl/rbsi_slab_div.sv =====
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
module rbsi_slab_div #(
    parameter  int CW = 32,
    parameter  int FB = 16,
    parameter  int SW = 66,
    localparam int NW = CW + 2 + FB,
    localparam int XW = NW + CW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [NW-1:0]   i_mag_lo,
    input  logic [NW-1:0]   i_mag_hi,
    input  logic            i_neg_lo,
    input  logic            i_neg_hi,
    input  logic [CW-1:0]   i_dmag,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [CW-1:0]   o_q_lo,
    output logic [CW-1:0]   o_q_hi,
    output logic            o_neg_lo,
    output logic            o_neg_hi,
    output logic            o_ovf_lo,
    output logic            o_ovf_hi,
    output logic [SW-1:0]   o_side
);
    logic [NW-1:0] mag_in [2];
    logic          neg_in [2];
    logic [XW-1:0] mag_x  [2];
    logic [XW-1:0] dsh_x;

    logic [CW-1:0] r_rem  [CW+1][2];
    logic [CW-1:0] r_qm   [CW+1][2];
    logic          r_neg  [CW+1][2];
    logic          r_ovf  [CW+1][2];
    logic [CW-1:0] r_dmag [CW+1];
    logic [SW-1:0] r_side [CW+1];
    logic          r_valid[CW+1];

    assign mag_in[0] = i_mag_lo;
    assign mag_in[1] = i_mag_hi;
    assign neg_in[0] = i_neg_lo;
    assign neg_in[1] = i_neg_hi;
    assign dsh_x     = XW'(i_dmag) << CW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_init
        assign mag_x[l] = XW'(mag_in[l]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[0][l] <= (mag_x[l] >= dsh_x);
                r_rem[0][l] <= CW'(mag_x[l] >> CW);
                r_qm[0][l]  <= mag_in[l][CW-1:0];
                r_neg[0][l] <= neg_in[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dmag[0] <= i_dmag;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < CW; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dmag[k+1] <= r_dmag[k];
                r_side[k+1] <= r_side[k];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [CW:0] trial, diff;
            assign trial = {r_rem[k][l], r_qm[k][l][CW-1]};
            assign diff  = trial - {1'b0, r_dmag[k]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1][l] <= diff[CW] ? trial[CW-1:0] : diff[CW-1:0];
                    r_qm[k+1][l]  <= {r_qm[k][l][CW-2:0], !diff[CW]};
                    r_neg[k+1][l] <= r_neg[k][l];
                    r_ovf[k+1][l] <= r_ovf[k][l];
                end
            end
        end
    end

    assign o_valid  = r_valid[CW];
    assign o_q_lo   = r_qm[CW][0];
    assign o_q_hi   = r_qm[CW][1];
    assign o_neg_lo = r_neg[CW][0];
    assign o_neg_hi = r_neg[CW][1];
    assign o_ovf_lo = r_ovf[CW][0];
    assign o_ovf_hi = r_ovf[CW][1];
    assign o_side   = r_side[CW];
endmodule

// ===== rtl/rbsi_hit.sv =====
// Slab merge, hit decision and entry point computation.
module rbsi_hit #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic        [CW-1:0]   i_q_lo  [2],
    input  logic        [CW-1:0]   i_q_hi  [2],
    input  logic                   i_neg_lo[2],
    input  logic                   i_neg_hi[2],
    input  logic                   i_ovf_lo[2],
    input  logic                   i_ovf_hi[2],
    input  rbsi_pkg::t_slab_flags  i_flags [2],
    input  logic signed [CW-1:0]   i_org   [2],
    input  logic signed [CW-1:0]   i_dir   [2],
    output logic                   o_valid,
    output logic                   o_is_hit,
    output logic signed [CW-1:0]   o_time,
    output logic signed [CW-1:0]   o_x,
    output logic signed [CW-1:0]   o_y
);
    localparam int PW = 2 * CW;
    localparam logic signed [CW-1:0]   T_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0]   T_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic        [CW-1:0]   Q_NEG = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW+FB:0]  ONE_X = (CW+FB+1)'(1) << FB;
    localparam logic signed [PW-1:0]   BIAS  = {{(PW-FB){1'b0}}, {FB{1'b1}}};
    localparam logic signed [PW:0]     S_MAX = (PW+1)'(T_MAX);
    localparam logic signed [PW:0]     S_MIN = (PW+1)'(T_MIN);

    function automatic logic signed [CW-1:0] sat_t(
        input logic [CW-1:0] q,
        input logic          neg,
        input logic          ovf
    );
        logic signed [CW-1:0] r;
        if (ovf) begin
            r = neg ? T_MIN : T_MAX;
        end else if (neg) begin
            r = (q > Q_NEG) ? T_MIN : $signed(-q);
        end else begin
            r = (q > $unsigned(T_MAX)) ? T_MAX : $signed(q);
        end
        return r;
    endfunction

    // stage 1: saturated slab times
    logic signed [CW-1:0]  t_lo[2], t_hi[2];
    logic signed [CW-1:0]  r_h1_tn[2], r_h1_tf[2], r_h1_org[2], r_h1_dir[2];
    rbsi_pkg::t_slab_flags r_h1_flags[2];
    logic                  r_h1_v;
    // stage 2: entry and exit
    logic signed [CW-1:0]  entry, leave;
    logic                  miss;
    logic signed [CW-1:0]  r_h2_entry, r_h2_leave, r_h2_org[2], r_h2_dir[2];
    logic                  r_h2_miss, r_h2_v;
    // stage 3: hit and products
    logic                  hit;
    logic signed [PW-1:0]  r_h3_prod[2];
    logic signed [CW-1:0]  r_h3_entry, r_h3_org[2];
    logic                  r_h3_hit, r_h3_v;
    // stage 4: scaling toward zero
    logic signed [PW-1:0]  biased[2];
    logic signed [PW-1:0]  r_h4_scl[2];
    logic signed [CW-1:0]  r_h4_entry, r_h4_org[2];
    logic                  r_h4_hit, r_h4_v;
    // stage 5: add origin, saturate
    logic signed [PW:0]    sum[2];
    logic signed [CW-1:0]  pt[2];

    for (genvar a = 0; a < 2; a++) begin : g_axis
        assign t_lo[a] = sat_t(i_q_lo[a], i_neg_lo[a], i_ovf_lo[a]);
        assign t_hi[a] = sat_t(i_q_hi[a], i_neg_hi[a], i_ovf_hi[a]);
        assign biased[a] = r_h3_prod[a][PW-1] ? r_h3_prod[a] + BIAS : r_h3_prod[a];
        assign sum[a] = (PW+1)'(r_h4_scl[a]) + (PW+1)'(r_h4_org[a]);
        assign pt[a]  = (sum[a] > S_MAX) ? T_MAX :
                        (sum[a] < S_MIN) ? T_MIN : sum[a][CW-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_h1_tn[a]    <= (t_lo[a] < t_hi[a]) ? t_lo[a] : t_hi[a];
                r_h1_tf[a]    <= (t_lo[a] < t_hi[a]) ? t_hi[a] : t_lo[a];
                r_h1_flags[a] <= i_flags[a];
                r_h1_org[a]   <= i_org[a];
                r_h1_dir[a]   <= i_dir[a];
                r_h2_org[a]   <= r_h1_org[a];
                r_h2_dir[a]   <= r_h1_dir[a];
                r_h3_prod[a]  <= r_h2_dir[a] * r_h2_entry;
                r_h3_org[a]   <= r_h2_org[a];
                r_h4_scl[a]   <= biased[a] >>> FB;
                r_h4_org[a]   <= r_h3_org[a];
            end
        end
    end

    always_comb begin
        entry = T_MIN;
        leave = T_MAX;
        miss  = 1'b0;
        for (int a = 0; a < 2; a++) begin
            if (r_h1_flags[a].dir_zero) begin
                miss = miss | r_h1_flags[a].outside;
            end else begin
                if (r_h1_tn[a] > entry) begin
                    entry = r_h1_tn[a];
                end
                if (r_h1_tf[a] < leave) begin
                    leave = r_h1_tf[a];
                end
            end
        end
    end

    assign hit = !r_h2_miss && (r_h2_leave > r_h2_entry)
              && !r_h2_leave[CW-1] && (r_h2_leave != '0)
              && ((CW+FB+1)'(r_h2_entry) < ONE_X);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h2_entry <= entry;
            r_h2_leave <= leave;
            r_h2_miss  <= miss;
            r_h3_hit   <= hit;
            r_h3_entry <= r_h2_entry;
            r_h4_hit   <= r_h3_hit;
            r_h4_entry <= r_h3_entry;
            o_is_hit   <= r_h4_hit;
            o_time     <= r_h4_hit ? r_h4_entry : '0;
            o_x        <= r_h4_hit ? pt[0] : '0;
            o_y        <= r_h4_hit ? pt[1] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1_v  <= 1'b0;
            r_h2_v  <= 1'b0;
            r_h3_v  <= 1'b0;
            r_h4_v  <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_h1_v  <= i_valid;
            r_h2_v  <= r_h1_v;
            r_h3_v  <= r_h2_v;
            r_h4_v  <= r_h3_v;
            o_valid <= r_h4_v;
        end
    end
endmodule
